// ===== rtl/point_triangle_distance_defines.svh =====
// ----------------------------------------------------------------------------
// point_triangle_distance_defines
// Assertion macros shared by the point to triangle distance block.
// ----------------------------------------------------------------------------
`ifndef POINT_TRIANGLE_DISTANCE_DEFINES_SVH
`define POINT_TRIANGLE_DISTANCE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define PTD_ASSERT_LAT(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ## n (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, codes and pipeline latencies of the point to triangle distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptd_pkg;

	typedef logic signed [31:0]  coord_t;
	typedef logic signed [32:0]  diff_t;
	typedef logic signed [29:0]  sdiff_t;
	typedef logic signed [59:0]  prod_t;
	typedef logic signed [63:0]  dot_t;
	typedef logic signed [127:0] wide_t;
	typedef logic signed [34:0]  quot_t;
	typedef logic signed [35:0]  wgt_t;
	typedef logic [2:0]          region_t;

	// scaled difference vectors
	localparam int NSV = 5;
	localparam logic [2:0] SV_02 = 3'd0;
	localparam logic [2:0] SV_01 = 3'd1;
	localparam logic [2:0] SV_12 = 3'd2;
	localparam logic [2:0] SV_P1 = 3'd3;
	localparam logic [2:0] SV_P2 = 3'd4;

	// dot products
	localparam int NDOT = 10;
	localparam logic [3:0] DOT_X   = 4'd0;
	localparam logic [3:0] DOT_Z   = 4'd1;
	localparam logic [3:0] DOT_Y   = 4'd2;
	localparam logic [3:0] DOT_W   = 4'd3;
	localparam logic [3:0] DOT_A   = 4'd4;
	localparam logic [3:0] DOT_B   = 4'd5;
	localparam logic [3:0] DOT_E2N = 4'd6;
	localparam logic [3:0] DOT_E2D = 4'd7;
	localparam logic [3:0] DOT_E3N = 4'd8;
	localparam logic [3:0] DOT_E3D = 4'd9;

	// region codes
	localparam region_t REG_INTERIOR = 3'd0;
	localparam region_t REG_EDGE12   = 3'd1;
	localparam region_t REG_EDGE02   = 3'd2;
	localparam region_t REG_EDGE01   = 3'd3;
	localparam region_t REG_CORNER0  = 3'd4;
	localparam region_t REG_CORNER1  = 3'd5;
	localparam region_t REG_CORNER2  = 3'd6;
	localparam region_t REG_NONE     = 3'd7;

	// configuration register indexes
	localparam logic CFG_EPS = 1'b0;
	localparam logic CFG_THR = 1'b1;

	// one in Q2.30, saturated quotient magnitude
	localparam wgt_t WONE = 36'sd1073741824;
	localparam logic [32:0] QMAX = '1;

	localparam int FRONT_LAT = 3;
	localparam int MULW_LAT  = 2;
	localparam int DIV_LAT   = 36;
	localparam int SQRT_LAT  = 32;

	function automatic logic [2:0] dot_lhs(logic [3:0] k);
		unique case (k)
			DOT_X, DOT_Z, DOT_E2D: return SV_02;
			DOT_Y, DOT_W:          return SV_12;
			DOT_A, DOT_B, DOT_E2N: return SV_P2;
			DOT_E3N:               return SV_P1;
			DOT_E3D:               return SV_01;
			default:               return SV_02;
		endcase
	endfunction

	function automatic logic [2:0] dot_rhs(logic [3:0] k);
		unique case (k)
			DOT_X, DOT_Y, DOT_A, DOT_E3N, DOT_E3D: return SV_01;
			DOT_Z, DOT_W, DOT_B:                   return SV_12;
			DOT_E2N, DOT_E2D:                      return SV_02;
			default:                               return SV_01;
		endcase
	endfunction

endpackage

// ===== rtl/ptd_delay.sv =====
// ----------------------------------------------------------------------------
// ptd_delay
// Fixed-length register line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		line_q[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			line_q[k] <= line_q[k-1];
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

// ===== rtl/ptd_front.sv =====
// ----------------------------------------------------------------------------
// ptd_front
// Coordinate differences, products of the 30 bit scaled differences and the ten dot products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_front import ptd_pkg::*; (
	input  logic   clk,
	input  coord_t pt [3],
	input  coord_t v0 [3],
	input  coord_t v1 [3],
	input  coord_t v2 [3],
	output diff_t  d0_s1 [3],
	output diff_t  d1_s1 [3],
	output diff_t  e_s1 [3],
	output dot_t   dot_s3 [NDOT]
);

	function automatic diff_t sub33(coord_t a, coord_t b);
		return diff_t'({a[31], a}) - diff_t'({b[31], b});
	endfunction

	diff_t  dv [NSV][3];
	diff_t  ev [3];
	sdiff_t sv_s1 [NSV][3];
	prod_t  prod_s2 [NDOT][3];

	// full differences
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv[SV_02][i] = sub33(v0[i], v2[i]);
			dv[SV_01][i] = sub33(v0[i], v1[i]);
			dv[SV_12][i] = sub33(v1[i], v2[i]);
			dv[SV_P1][i] = sub33(pt[i], v1[i]);
			dv[SV_P2][i] = sub33(pt[i], v2[i]);
			ev[i]        = sub33(v2[i], pt[i]);
		end
	end

	// stage 1: floor shift by three is a drop of the low bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < NSV; j++) begin
				sv_s1[j][i] <= dv[j][i][32:3];
			end
			d0_s1[i] <= dv[SV_02][i];
			d1_s1[i] <= dv[SV_12][i];
			e_s1[i]  <= ev[i];
		end
	end

	// stage 2: per-axis products
	always_ff @(posedge clk) begin
		for (int k = 0; k < NDOT; k++) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[k][i] <= sv_s1[dot_lhs(4'(k))][i] * sv_s1[dot_rhs(4'(k))][i];
			end
		end
	end

	// stage 3: sums over the axes
	always_ff @(posedge clk) begin
		for (int k = 0; k < NDOT; k++) begin
			dot_s3[k] <= dot_t'(prod_s2[k][0]) + dot_t'(prod_s2[k][1]) + dot_t'(prod_s2[k][2]);
		end
	end

endmodule

// ===== rtl/ptd_mul_wide.sv =====
// ----------------------------------------------------------------------------
// ptd_mul_wide
// Signed 64 x 64 multiplier in two stages built from four 32 x 32 products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_mul_wide import ptd_pkg::*; (
	input  logic  clk,
	input  dot_t  a,
	input  dot_t  b,
	output wide_t prod
);

	logic [63:0]  ma, mb;
	logic [63:0]  pp_s1 [4];
	logic         neg_s1;
	logic [127:0] sum;
	wide_t        prod_s2;

	assign ma = a[63] ? 64'(-a) : 64'(a);
	assign mb = b[63] ? 64'(-b) : 64'(b);

	// stage 1: partial products of the magnitudes
	always_ff @(posedge clk) begin
		pp_s1[0] <= ma[31:0]  * mb[31:0];
		pp_s1[1] <= ma[31:0]  * mb[63:32];
		pp_s1[2] <= ma[63:32] * mb[31:0];
		pp_s1[3] <= ma[63:32] * mb[63:32];
		neg_s1   <= a[63] ^ b[63];
	end

	// stage 2: recombine and restore the sign
	assign sum = {64'd0, pp_s1[0]} + {32'd0, pp_s1[1], 32'd0}
		+ {32'd0, pp_s1[2], 32'd0} + {pp_s1[3], 64'd0};

	always_ff @(posedge clk) begin
		prod_s2 <= neg_s1 ? wide_t'(-sum) : wide_t'(sum);
	end

	assign prod = prod_s2;

endmodule

// ===== rtl/ptd_div.sv =====
// ----------------------------------------------------------------------------
// ptd_div
// Pipelined Q2.30 quotient num/den, one restoring step per stage, truncated
// toward zero with the magnitude saturated to 33 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_div import ptd_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output quot_t        quot
);

	localparam int RW    = W + 4;
	localparam int STEPS = 33;

	logic [W-1:0]  nm_s0, dm_s0;
	logic          neg_s0, dz_s0;
	logic [RW-1:0] rem_s [STEPS+1];
	logic [RW-1:0] d8_s  [STEPS+1];
	logic [32:0]   q_s   [STEPS+1];
	logic          sat_s [STEPS+1];
	logic          neg_s [STEPS+1];
	logic          dz_s  [STEPS+1];
	logic [32:0]   qm;
	quot_t         quot_s;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		nm_s0  <= num[W-1] ? W'(-num) : num;
		dm_s0  <= den[W-1] ? W'(-den) : den;
		neg_s0 <= num[W-1] ^ den[W-1];
		dz_s0  <= (den == '0);
	end

	// setup: saturate when the quotient reaches 8
	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(nm_s0);
		d8_s[0]  <= {1'b0, dm_s0, 3'b000};
		sat_s[0] <= RW'(nm_s0) >= {1'b0, dm_s0, 3'b000};
		q_s[0]   <= '0;
		neg_s[0] <= neg_s0;
		dz_s[0]  <= dz_s0;
	end

	// one quotient bit per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [RW-1:0] r2;
		logic          ge;
		assign r2 = {rem_s[k][RW-2:0], 1'b0};
		assign ge = (r2 >= d8_s[k]);
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? (r2 - d8_s[k]) : r2;
			q_s[k+1]   <= {q_s[k][31:0], ge};
			d8_s[k+1]  <= d8_s[k];
			sat_s[k+1] <= sat_s[k];
			neg_s[k+1] <= neg_s[k];
			dz_s[k+1]  <= dz_s[k];
		end
	end

	// clamp and sign
	always_comb begin
		if (dz_s[STEPS]) begin
			qm = '0;
		end else if (sat_s[STEPS]) begin
			qm = QMAX;
		end else begin
			qm = q_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		quot_s <= neg_s[STEPS] ? -quot_t'({2'b00, qm}) : quot_t'({2'b00, qm});
	end

	assign quot = quot_s;

endmodule

// ===== rtl/ptd_sqrt.sv =====
// ----------------------------------------------------------------------------
// ptd_sqrt
// Pipelined floor square root of a 64 bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_sqrt (
	input  logic        clk,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	localparam int STEPS = 32;

	logic [32:0] rem_s  [STEPS+1];
	logic [31:0] root_s [STEPS+1];
	logic [63:0] xs_s   [STEPS+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign xs_s[0]   = radicand;

	// bring down two bits, try root*4+1
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [34:0] r2;
		logic [34:0] trial;
		logic        ge;
		assign r2    = {rem_s[k], xs_s[k][63:62]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = (r2 >= trial);
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? 33'(r2 - trial) : r2[32:0];
			root_s[k+1] <= {root_s[k][30:0], ge};
			xs_s[k+1]   <= {xs_s[k][61:0], 2'b00};
		end
	end

	assign root = root_s[STEPS];

endmodule

// ===== rtl/point_triangle_distance.sv =====
// ----------------------------------------------------------------------------
// point_triangle_distance
// Distance from a query point to a triangle in Q16.16 with region code.
// ----------------------------------------------------------------------------
//  channel   signals                                     transfer
//  input     start, busy, point_*, corner0..2_*          start && !busy
//  result    done, distance, region, overflowed          done, one cycle
//  config    cfg_write, cfg_index, cfg_data              cfg_write
//
//  A query may be started on every cycle; busy is always low.
//  Its result passes in order through the dot products, the wide
//  multipliers, the determinant register, the restoring dividers,
//  classification, the offset and squares, the square root and the
//  output register. The divider chain is the longest of these steps.
//  Reset clears the valid line and the two registers; items in flight are
//  dropped. The result side has no stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_triangle_distance import ptd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  logic signed [31:0]  corner0_x,
	input  logic signed [31:0]  corner0_y,
	input  logic signed [31:0]  corner0_z,
	input  logic signed [31:0]  corner1_x,
	input  logic signed [31:0]  corner1_y,
	input  logic signed [31:0]  corner1_z,
	input  logic signed [31:0]  corner2_x,
	input  logic signed [31:0]  corner2_y,
	input  logic signed [31:0]  corner2_z,
	input  logic                cfg_write,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                done,
	output logic [31:0]         distance,
	output logic [2:0]          region,
	output logic                overflowed
);

`include "point_triangle_distance_defines.svh"

	localparam int PIPE_LAT = FRONT_LAT + MULW_LAT + 1 + DIV_LAT + 2 + 5 + SQRT_LAT + 1;
	localparam int GEO_LAT  = MULW_LAT + 1 + DIV_LAT + 2 + FRONT_LAT - 1;
	localparam int DW       = 33;

	// configuration
	logic [29:0] eps_q;
	logic [31:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 30'd1;
			thr_q <= 32'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_EPS: eps_q <= cfg_data[29:0];
				CFG_THR: thr_q <= cfg_data;
			endcase
		end
	end

	// valid line
	logic                accept;
	logic [PIPE_LAT-1:0] vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	// front end
	coord_t pt_w [3], v0_w [3], v1_w [3], v2_w [3];
	diff_t  d0_s1 [3], d1_s1 [3], e_s1 [3];
	dot_t   dot_s3 [NDOT];

	assign pt_w = '{point_x, point_y, point_z};
	assign v0_w = '{corner0_x, corner0_y, corner0_z};
	assign v1_w = '{corner1_x, corner1_y, corner1_z};
	assign v2_w = '{corner2_x, corner2_y, corner2_z};

	ptd_front u_front (
		.clk    (clk),
		.pt     (pt_w),
		.v0     (v0_w),
		.v1     (v1_w),
		.v2     (v2_w),
		.d0_s1  (d0_s1),
		.d1_s1  (d1_s1),
		.e_s1   (e_s1),
		.dot_s3 (dot_s3)
	);

	// determinant and weight numerators
	wide_t xw_s5, zy_s5, wa_s5, yb_s5, xb_s5, za_s5;

	ptd_mul_wide u_mul_xw (.clk(clk), .a(dot_s3[DOT_X]), .b(dot_s3[DOT_W]), .prod(xw_s5));
	ptd_mul_wide u_mul_zy (.clk(clk), .a(dot_s3[DOT_Z]), .b(dot_s3[DOT_Y]), .prod(zy_s5));
	ptd_mul_wide u_mul_wa (.clk(clk), .a(dot_s3[DOT_W]), .b(dot_s3[DOT_A]), .prod(wa_s5));
	ptd_mul_wide u_mul_yb (.clk(clk), .a(dot_s3[DOT_Y]), .b(dot_s3[DOT_B]), .prod(yb_s5));
	ptd_mul_wide u_mul_xb (.clk(clk), .a(dot_s3[DOT_X]), .b(dot_s3[DOT_B]), .prod(xb_s5));
	ptd_mul_wide u_mul_za (.clk(clk), .a(dot_s3[DOT_Z]), .b(dot_s3[DOT_A]), .prod(za_s5));

	wide_t den, thr_w;
	wide_t den_s6, na_s6, nb_s6;
	logic  degen_s6;

	assign den   = xw_s5 - zy_s5;
	assign thr_w = wide_t'({96'd0, thr_q});

	// degenerate when |den| < threshold or den is zero
	always_ff @(posedge clk) begin
		den_s6   <= den;
		na_s6    <= wa_s5 - yb_s5;
		nb_s6    <= xb_s5 - za_s5;
		degen_s6 <= (den == '0) || ((den < thr_w) && (den > -thr_w));
	end

	// weight quotients
	quot_t a_s42, b_s42, t1_s39, t2_s39, t3_s39;
	logic  degen_s42;

	ptd_div #(.W(128)) u_div_a (.clk(clk), .num(na_s6), .den(den_s6), .quot(a_s42));
	ptd_div #(.W(128)) u_div_b (.clk(clk), .num(nb_s6), .den(den_s6), .quot(b_s42));

	// edge ratios run alongside and catch up
	ptd_div #(.W(64)) u_div_t1 (.clk(clk), .num(dot_s3[DOT_B]), .den(dot_s3[DOT_W]),
		.quot(t1_s39));
	ptd_div #(.W(64)) u_div_t2 (.clk(clk), .num(dot_s3[DOT_E2N]), .den(dot_s3[DOT_E2D]),
		.quot(t2_s39));
	ptd_div #(.W(64)) u_div_t3 (.clk(clk), .num(dot_s3[DOT_E3N]), .den(dot_s3[DOT_E3D]),
		.quot(t3_s39));

	logic [104:0] edge_s39, edge_s42;
	assign edge_s39 = {t1_s39, t2_s39, t3_s39};

	ptd_delay #(.WIDTH(105), .DEPTH(MULW_LAT + 1)) u_dly_edge (
		.clk (clk), .din (edge_s39), .dout (edge_s42)
	);

	ptd_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_dly_degen (
		.clk (clk), .din (degen_s6), .dout (degen_s42)
	);

	// classification, first half: third weight and complements
	wgt_t a_s43, b_s43, c_s43, ab_s43, oma_s43;
	wgt_t t1_s43, t2_s43, t3_s43, u1_s43, u2_s43, u3_s43;
	logic degen_s43;
	wgt_t a_w, b_w, t1_w, t2_w, t3_w;

	assign a_w  = wgt_t'(a_s42);
	assign b_w  = wgt_t'(b_s42);
	assign t1_w = wgt_t'(quot_t'(edge_s42[104:70]));
	assign t2_w = wgt_t'(quot_t'(edge_s42[69:35]));
	assign t3_w = wgt_t'(quot_t'(edge_s42[34:0]));

	always_ff @(posedge clk) begin
		a_s43     <= a_w;
		b_s43     <= b_w;
		c_s43     <= WONE - a_w - b_w;
		ab_s43    <= a_w + b_w;
		oma_s43   <= WONE - a_w;
		t1_s43    <= t1_w;
		t2_s43    <= t2_w;
		t3_s43    <= t3_w;
		u1_s43    <= WONE - t1_w;
		u2_s43    <= WONE - t2_w;
		u3_s43    <= WONE - t3_w;
		degen_s43 <= degen_s42;
	end

	// classification, second half: region and foot weights
	function automatic logic is_pos(wgt_t x);
		return !x[35] && (x != '0);
	endfunction

	function automatic logic is_zero(wgt_t x, wgt_t eps);
		return (x < eps) && (x > -eps);
	endfunction

	wgt_t    eps_w;
	logic    pa, pb, pc, na, nb, nc, za, zb, zc, zna, znb, znc;
	wgt_t    wa_n, wb_n;
	region_t reg_n;
	logic    ok_n;
	wgt_t    wa_s44, wb_s44;
	region_t region_s44;
	logic    ok_s44;

	assign eps_w = wgt_t'({6'd0, eps_q});
	assign pa  = is_pos(a_s43);
	assign pb  = is_pos(b_s43);
	assign pc  = is_pos(c_s43);
	assign na  = a_s43[35];
	assign nb  = b_s43[35];
	assign nc  = c_s43[35];
	assign za  = is_zero(a_s43, eps_w);
	assign zb  = is_zero(b_s43, eps_w);
	assign zc  = is_zero(c_s43, eps_w);
	assign zna = za || na;
	assign znb = zb || nb;
	assign znc = zc || nc;

	always_comb begin
		wa_n  = '0;
		wb_n  = '0;
		reg_n = REG_NONE;
		ok_n  = 1'b1;
		priority if (pa && pb && pc) begin
			wa_n  = a_s43;
			wb_n  = b_s43;
			reg_n = REG_INTERIOR;
		end else if (za && pb && pc) begin
			wb_n  = b_s43;
			reg_n = REG_EDGE12;
		end else if (pa && zb && pc) begin
			wa_n  = ab_s43;
			reg_n = REG_EDGE02;
		end else if (pa && pb && zc) begin
			wa_n  = a_s43;
			wb_n  = oma_s43;
			reg_n = REG_EDGE01;
		end else if (zna && znb && pc) begin
			reg_n = REG_CORNER2;
		end else if (pa && znb && znc) begin
			wa_n  = WONE;
			reg_n = REG_CORNER0;
		end else if (zna && pb && znc) begin
			wb_n  = WONE;
			reg_n = REG_CORNER1;
		end else if (na && pb && pc) begin
			// beyond edge V1V2: clamp the projection
			if (u1_s43[35]) begin
				wb_n  = WONE;
				reg_n = REG_CORNER1;
			end else if (t1_s43[35]) begin
				reg_n = REG_CORNER2;
			end else begin
				wb_n  = t1_s43;
				reg_n = REG_EDGE12;
			end
		end else if (pa && nb && pc) begin
			// beyond edge V0V2
			if (u2_s43[35]) begin
				wa_n  = WONE;
				reg_n = REG_CORNER0;
			end else if (t2_s43[35]) begin
				reg_n = REG_CORNER2;
			end else begin
				wa_n  = t2_s43;
				reg_n = REG_EDGE02;
			end
		end else if (pa && pb && nc) begin
			// beyond edge V0V1, ratio measured from V1
			if (t3_s43[35]) begin
				wb_n  = WONE;
				reg_n = REG_CORNER1;
			end else if (u3_s43[35]) begin
				wa_n  = WONE;
				reg_n = REG_CORNER0;
			end else begin
				wa_n  = t3_s43;
				wb_n  = u3_s43;
				reg_n = REG_EDGE01;
			end
		end else begin
			ok_n = 1'b0;
		end
		if (degen_s43) begin
			ok_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wa_s44     <= wa_n;
		wb_s44     <= wb_n;
		region_s44 <= reg_n;
		ok_s44     <= ok_n;
	end

	// triangle geometry delayed to the distance stages
	logic [9*DW-1:0] geo_s1, geo_s44;
	diff_t           d0_s44 [3], d1_s44 [3], e_s44 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geo_s1[i*DW +: DW]     = d0_s1[i];
			geo_s1[(3+i)*DW +: DW] = d1_s1[i];
			geo_s1[(6+i)*DW +: DW] = e_s1[i];
		end
	end

	ptd_delay #(.WIDTH(9*DW), .DEPTH(GEO_LAT)) u_dly_geo (
		.clk (clk), .din (geo_s1), .dout (geo_s44)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d0_s44[i] = diff_t'(geo_s44[i*DW +: DW]);
			d1_s44[i] = diff_t'(geo_s44[(3+i)*DW +: DW]);
			e_s44[i]  = diff_t'(geo_s44[(6+i)*DW +: DW]);
		end
	end

	// offset from the point to the foot, exact in Q18.46
	logic signed [68:0] pa_s45 [3], pb_s45 [3];
	diff_t              e_s45 [3];
	logic signed [71:0] ofs_s46 [3];
	logic [71:0]        mag [3];
	logic [31:0]        c_s47 [3];
	logic [2:0]         big_s47;
	logic [63:0]        sq_s48 [3];
	logic               big_s48;
	logic [65:0]        acc;
	logic [63:0]        rad_s49;
	logic               sat_s49;
	region_t            region_s45, region_s46, region_s47, region_s48, region_s49;
	logic               ok_s45, ok_s46, ok_s47, ok_s48, ok_s49;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s45[i] <= wa_s44 * d0_s44[i];
			pb_s45[i] <= wb_s44 * d1_s44[i];
			e_s45[i]  <= e_s44[i];
		end
		region_s45 <= region_s44;
		ok_s45     <= ok_s44;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ofs_s46[i] <= 72'(pa_s45[i]) + 72'(pb_s45[i]) + (72'(e_s45[i]) <<< 30);
		end
		region_s46 <= region_s45;
		ok_s46     <= ok_s45;
	end

	// magnitude rounded half up to Q16.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = ofs_s46[i][71] ? (~ofs_s46[i] + 72'h2000_0001) : (ofs_s46[i] + 72'h2000_0000);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s47[i]   <= mag[i][61:30];
			big_s47[i] <= |mag[i][71:62];
		end
		region_s47 <= region_s46;
		ok_s47     <= ok_s46;
	end

	// squares; a component of 2^32 or more already saturates
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s48[i] <= c_s47[i] * c_s47[i];
		end
		big_s48    <= |big_s47;
		region_s48 <= region_s47;
		ok_s48     <= ok_s47;
	end

	assign acc = {2'b00, sq_s48[0]} + {2'b00, sq_s48[1]} + {2'b00, sq_s48[2]};

	always_ff @(posedge clk) begin
		rad_s49    <= acc[63:0];
		sat_s49    <= big_s48 || (acc[65:64] != 2'b00);
		region_s49 <= region_s48;
		ok_s49     <= ok_s48;
	end

	// square root with its side data
	logic [31:0] root_s81;
	logic [4:0]  side_s49, side_s81;

	ptd_sqrt u_sqrt (.clk(clk), .radicand(rad_s49), .root(root_s81));

	assign side_s49 = {ok_s49, sat_s49, region_s49};

	ptd_delay #(.WIDTH(5), .DEPTH(SQRT_LAT)) u_dly_side (
		.clk (clk), .din (side_s49), .dout (side_s81)
	);

	// output register
	logic [31:0] dist_q;
	region_t     region_q;
	logic        ovf_q;

	always_ff @(posedge clk) begin
		if (!side_s81[4]) begin
			dist_q   <= '1;
			region_q <= REG_NONE;
			ovf_q    <= 1'b0;
		end else if (side_s81[3]) begin
			dist_q   <= '1;
			region_q <= side_s81[2:0];
			ovf_q    <= 1'b1;
		end else begin
			dist_q   <= root_s81;
			region_q <= side_s81[2:0];
			ovf_q    <= 1'b0;
		end
	end

	assign done       = vld_q[PIPE_LAT-1];
	assign distance   = dist_q;
	assign region     = region_q;
	assign overflowed = ovf_q;

	// checks
	`PTD_ASSERT_LAT(a_latency, start && !busy, PIPE_LAT, done, "accepted query gave no result")
	`PTD_ASSERT_IMP(a_origin, done, $past(start && !busy, PIPE_LAT), "result without a query")
	`PTD_ASSERT_IMP(a_sentinel, done && region == REG_NONE, distance == '1 && !overflowed,
		"degenerate result not all ones")
	`PTD_ASSERT_IMP(a_saturate, done && overflowed, distance == '1 && region != REG_NONE,
		"saturated result malformed")

endmodule

// ===== sim/point_triangle_distance_tb.sv =====
// ----------------------------------------------------------------------------
// point_triangle_distance_tb
// Self-checking bench for the point to triangle distance block. An internal
// distance model predicts distance, region and saturation for every query
// transfer. Each result strobe is compared in order against those predictions.
// Stimulus runs a directed set first, then random queries under several
// tolerance and threshold settings, with random start gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_triangle_distance_tb;
	import ptd_pkg::*;

	localparam int     STALL_LIMIT = 5000;
	localparam longint Q_ONE       = 64'sd1073741824;
	localparam longint Q_SAT       = (64'sd1 << 33) - 1;
	localparam longint FX          = 64'sd65536;

	typedef logic signed [127:0] wide_s;

	typedef struct packed {
		logic [31:0] dist_val;
		region_t     reg_code;
		logic        sat;
	} answer_t;

	// ------------------------------------------------------------------------
	// distance model and answer queue
	// ------------------------------------------------------------------------
	class dist_scoreboard;
		logic [29:0] eps;
		logic [31:0] thr;
		answer_t     pending[$];
		int          errors;

		function new();
			eps = 30'd1;
			thr = 32'd1;
			errors = 0;
		endfunction

		function void set_regs(logic [29:0] e, logic [31:0] t);
			eps = e;
			thr = t;
		endfunction

		// Q2.30 quotient truncated toward zero, magnitude saturated
		function longint quot(wide_s num, wide_s den);
			logic [127:0] n;
			logic [127:0] d;
			logic [191:0] q;
			if (den == 0)
				return 0;
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			if (n >= (d << 3))
				q = Q_SAT;
			else
				q = ({64'd0, n} << 30) / {64'd0, d};
			return ((num < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function bit wz(longint x);
			longint m;
			m = (x < 0) ? -x : x;
			return m < longint'({34'd0, eps});
		endfunction

		function bit wzn(longint x);
			return wz(x) || x < 0;
		endfunction

		// floor sqrt of squared distance from P to the weighted foot
		function longint unsigned foot_dist(longint wa, longint wb,
				longint d0[3], longint d1[3], longint e[3]);
			wide_s        s;
			logic [127:0] m;
			logic [127:0] c;
			logic [127:0] acc;
			logic [127:0] t;
			logic [127:0] root;
			acc = 0;
			root = 0;
			for (int i = 0; i < 3; i++) begin
				s = wide_s'(wa) * wide_s'(d0[i]) + wide_s'(wb) * wide_s'(d1[i])
					+ wide_s'(e[i]) * wide_s'(Q_ONE);
				m = (s < 0) ? -s : s;
				c = (m + (128'd1 << 29)) >> 30;
				acc += c * c;
			end
			for (int i = 39; i >= 0; i--) begin
				t = root | (128'd1 << i);
				if (t * t <= acc)
					root = t;
			end
			return root[63:0];
		endfunction

		function longint dot(longint u[3], longint v[3]);
			return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
		endfunction

		// query transfer: predict its answer
		function void note_query(coord_t f[12]);
			longint p[3], v0[3], v1[3], v2[3];
			longint d0[3], d1[3], e[3], s02[3], s01[3], s12[3], sp1[3], sp2[3];
			longint X, Y, Z, W, A, B, a, b, c, wa, wb, t, u;
			wide_s  den, na, nb;
			logic [127:0] dmag;
			answer_t ans;
			bit hit;
			longint unsigned d;
			for (int i = 0; i < 3; i++) begin
				p[i] = f[i];
				v0[i] = f[3 + i];
				v1[i] = f[6 + i];
				v2[i] = f[9 + i];
				d0[i] = v0[i] - v2[i];
				d1[i] = v1[i] - v2[i];
				e[i] = v2[i] - p[i];
				s02[i] = (v0[i] - v2[i]) >>> 3;
				s01[i] = (v0[i] - v1[i]) >>> 3;
				s12[i] = (v1[i] - v2[i]) >>> 3;
				sp1[i] = (p[i] - v1[i]) >>> 3;
				sp2[i] = (p[i] - v2[i]) >>> 3;
			end
			X = dot(s02, s01); Z = dot(s02, s12); Y = dot(s12, s01);
			W = dot(s12, s12); A = dot(sp2, s01); B = dot(sp2, s12);
			den = wide_s'(X) * wide_s'(W) - wide_s'(Z) * wide_s'(Y);
			dmag = (den < 0) ? -den : den;
			ans = '{dist_val: '1, reg_code: REG_NONE, sat: 1'b0};
			if (dmag != 0 && dmag >= {96'd0, thr}) begin
				na = wide_s'(W) * wide_s'(A) - wide_s'(Y) * wide_s'(B);
				nb = wide_s'(X) * wide_s'(B) - wide_s'(Z) * wide_s'(A);
				a = quot(na, den);
				b = quot(nb, den);
				c = Q_ONE - a - b;
				wa = 0;
				wb = 0;
				hit = 1'b1;
				if (a > 0 && b > 0 && c > 0) begin
					wa = a; wb = b; ans.reg_code = REG_INTERIOR;
				end else if (wz(a) && b > 0 && c > 0) begin
					wb = b; ans.reg_code = REG_EDGE12;
				end else if (a > 0 && wz(b) && c > 0) begin
					wa = Q_ONE - c; ans.reg_code = REG_EDGE02;
				end else if (a > 0 && b > 0 && wz(c)) begin
					wa = a; wb = Q_ONE - a; ans.reg_code = REG_EDGE01;
				end else if (wzn(a) && wzn(b) && c > 0) begin
					ans.reg_code = REG_CORNER2;
				end else if (a > 0 && wzn(b) && wzn(c)) begin
					wa = Q_ONE; ans.reg_code = REG_CORNER0;
				end else if (wzn(a) && b > 0 && wzn(c)) begin
					wb = Q_ONE; ans.reg_code = REG_CORNER1;
				end else if (a < 0 && b > 0 && c > 0) begin
					// beyond edge V1V2: clamp the projection
					t = quot(wide_s'(B), wide_s'(W));
					u = Q_ONE - t;
					if (u < 0) begin wb = Q_ONE; ans.reg_code = REG_CORNER1; end
					else if (t < 0) ans.reg_code = REG_CORNER2;
					else begin wb = t; ans.reg_code = REG_EDGE12; end
				end else if (a > 0 && b < 0 && c > 0) begin
					// beyond edge V0V2
					t = quot(wide_s'(dot(sp2, s02)), wide_s'(dot(s02, s02)));
					u = Q_ONE - t;
					if (u < 0) begin wa = Q_ONE; ans.reg_code = REG_CORNER0; end
					else if (t < 0) ans.reg_code = REG_CORNER2;
					else begin wa = t; ans.reg_code = REG_EDGE02; end
				end else if (a > 0 && b > 0 && c < 0) begin
					// beyond edge V0V1
					t = quot(wide_s'(dot(sp1, s01)), wide_s'(dot(s01, s01)));
					u = Q_ONE - t;
					if (t < 0) begin wb = Q_ONE; ans.reg_code = REG_CORNER1; end
					else if (u < 0) begin wa = Q_ONE; ans.reg_code = REG_CORNER0; end
					else begin wa = t; wb = u; ans.reg_code = REG_EDGE01; end
				end else begin
					hit = 1'b0;
				end
				if (hit) begin
					d = foot_dist(wa, wb, d0, d1, e);
					if (d > 64'hFFFF_FFFF) begin
						ans.dist_val = '1; ans.sat = 1'b1;
					end else begin
						ans.dist_val = d[31:0]; ans.sat = 1'b0;
					end
				end
			end
			pending.push_back(ans);
		endfunction

		// result transfer: compare with the oldest prediction
		function void check_answer(logic [31:0] dist_got, region_t rc, logic sat);
			answer_t ex;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected: dist %h region %0d sat %b",
					$time, dist_got, rc, sat);
				errors++;
				return;
			end
			ex = pending.pop_front();
			if (dist_got !== ex.dist_val) begin
				$display("%0t: distance expected %h actual %h", $time, ex.dist_val,
					dist_got);
				errors++;
			end
			if (rc !== ex.reg_code) begin
				$display("%0t: region expected %0d actual %0d", $time, ex.reg_code, rc);
				errors++;
			end
			if (sat !== ex.sat) begin
				$display("%0t: overflowed expected %b actual %b", $time, ex.sat, sat);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	coord_t      q[12] = '{default: '0};
	logic        cfg_write = 1'b0;
	logic [0:0]  cfg_index = CFG_EPS;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [31:0] distance;
	logic [2:0]  region;
	logic        overflowed;

	dist_scoreboard sb = new();
	bit idling = 1'b1;
	int stall_cnt = 0;

	always #5 clk = ~clk;

	point_triangle_distance uut (
		.clk, .arst_n, .start, .busy,
		.point_x(q[0]), .point_y(q[1]), .point_z(q[2]),
		.corner0_x(q[3]), .corner0_y(q[4]), .corner0_z(q[5]),
		.corner1_x(q[6]), .corner1_y(q[7]), .corner1_z(q[8]),
		.corner2_x(q[9]), .corner2_y(q[10]), .corner2_z(q[11]),
		.cfg_write, .cfg_index, .cfg_data,
		.done, .distance, .region, .overflowed
	);

	// transfer monitors
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_query(q);
		if (arst_n && done)
			sb.check_answer(distance, region, overflowed);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_write || !arst_n)
			stall_cnt <= 0;
		else if (stall_cnt == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	task automatic send_query(longint f[12]);
		if (idling && $urandom_range(99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		for (int i = 0; i < 12; i++)
			q[i] <= coord_t'(f[i]);
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// drain, then write both registers on back-to-back cycles
	task automatic write_regs(logic [29:0] e, logic [31:0] t);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_EPS;
		cfg_data <= {2'b00, e};
		@(posedge clk);
		cfg_index <= CFG_THR;
		cfg_data <= t;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_regs(e, t);
	endtask

	task automatic tri_query(longint px, py, pz, ax, ay, az, bx, by, bz,
			cx, cy, cz);
		longint f[12];
		f = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
		send_query(f);
	endtask

	function automatic longint rnd_coord(int bits);
		logic signed [31:0] v;
		v = $urandom;
		return longint'(v >>> (32 - bits));
	endfunction

	// random query; mostly sane triangles with points near features
	task automatic rnd_query();
		longint f[12];
		int     bits;
		int     mode;
		int     k;
		int     j;
		case ($urandom_range(3))
			0: bits = 12;
			1: bits = 20;
			2: bits = 26;
			default: bits = 32;
		endcase
		for (int i = 3; i < 12; i++)
			f[i] = rnd_coord(bits);
		mode = $urandom_range(9);
		k = $urandom_range(2);
		j = (k + 1) % 3;
		for (int i = 0; i < 3; i++) begin
			case (mode)
				0, 1: f[i] = rnd_coord(bits);
				// at a corner, with a little noise
				2: f[i] = f[3 + 3 * k + i] + rnd_coord(6);
				// near an edge midpoint
				3, 4: f[i] = (f[3 + 3 * k + i] + f[3 + 3 * j + i]) / 2 + rnd_coord(4);
				// centroid, pushed off the plane
				5, 6: f[i] = (f[3 + i] + f[6 + i] + f[9 + i]) / 3 + rnd_coord(bits - 2);
				// shared corner: degenerate triangle
				7: begin
					f[3 + 3 * j + i] = f[3 + 3 * k + i];
					f[i] = rnd_coord(bits);
				end
				default: f[i] = f[3 + 3 * k + i] * 2 - f[3 + 3 * j + i];
			endcase
			f[i] = longint'(coord_t'(f[i]));
		end
		send_query(f);
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		longint mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: right triangle in z = 0, legs of 4
		tri_query(1*FX, 1*FX, 3*FX, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(3*FX, 3*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(-1*FX, 2*FX, FX, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(2*FX, -1*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(-1*FX, -1*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(6*FX, -1*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(-1*FX, 6*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(0, 0, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(4*FX, 0, FX, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(2*FX, 2*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(0, 2*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(2*FX, 0, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(-3*FX, 8*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		tri_query(8*FX, -3*FX, 0, 0, 0, 0, 4*FX, 0, 0, 0, 4*FX, 0);
		// degenerate: equal corners, collinear corners, all zero
		tri_query(FX, FX, FX, 5, 5, 5, 5, 5, 5, 5, 5, 5);
		tri_query(FX, 2*FX, 0, 0, 0, 0, FX, FX, FX, 2*FX, 2*FX, 2*FX);
		tri_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// field extremes and saturated distance
		tri_query(mx, mx, mx, mn, mn, mn, mn, mx, mn, mx, mn, mn);
		tri_query(mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mx);
		tri_query(mx, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn);
		tri_query(0, 0, mx, mn, mn, 0, mx, mn, 0, 0, mx, 0);
		tri_query(-1, -1, -1, mn, 0, 0, 0, mx, 0, 0, 0, mx);

		// random phases under several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_regs(30'd1, 32'd1);
				1: write_regs(30'd0, 32'd0);
				2: write_regs(30'h3FFF_FFFF, 32'hFFFF_FFFF);
				3: write_regs(30'd1 << $urandom_range(4, 24), $urandom >> $urandom_range(31));
				default: write_regs(30'($urandom_range(0, 1 << 12)),
					32'd1 << $urandom_range(31));
			endcase
			for (int n = 0; n < 160; n++) begin
				idling = !(ph == 1 && n >= 40 && n < 140);
				rnd_query();
			end
		end

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_delay.sv
rtl/ptd_front.sv
rtl/ptd_mul_wide.sv
rtl/ptd_div.sv
rtl/ptd_sqrt.sv
rtl/point_triangle_distance.sv
sim/point_triangle_distance_tb.sv
